### rtl/core/mep_pkg.sv
package mep_pkg;

  localparam int unsigned PIX_W   = 12;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned Z_W     = 36;
  localparam int unsigned FRAC_W  = 28;
  localparam int unsigned PROD_W  = 64;
  localparam int unsigned SQ_W    = 59;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_REAL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_IMAG   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_REAL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_IMAG = 3'd5;

  localparam logic [PIX_W-1:0]          CENTER_X_RST    = 12'd400;
  localparam logic [PIX_W-1:0]          CENTER_Y_RST    = 12'd300;
  localparam logic signed [COORD_W-1:0] STEP_REAL_RST   = 32'sd1174405;
  localparam logic signed [COORD_W-1:0] STEP_IMAG_RST   = 32'sd894785;
  localparam logic signed [COORD_W-1:0] OFFSET_REAL_RST = -32'sd134217728;
  localparam logic signed [COORD_W-1:0] OFFSET_IMAG_RST = 32'sd0;

  localparam logic signed [Z_W-1:0] Z_TWO     = 36'sh0_2000_0000;
  localparam logic signed [Z_W-1:0] Z_NEG_TWO = -36'sh0_2000_0000;
  localparam logic [SQ_W:0]         RAD_FOUR  = 60'h400_0000_0000_0000;

  localparam logic signed [PROD_W-1:0] COORD_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [PROD_W-1:0] COORD_MIN = -64'sh0000_0000_8000_0000;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b0_0000_0001,
    ST_MAP_X = 9'b0_0000_0010,
    ST_MAP_Y = 9'b0_0000_0100,
    ST_MAP_C = 9'b0_0000_1000,
    ST_SQ_R  = 9'b0_0001_0000,
    ST_SQ_I  = 9'b0_0010_0000,
    ST_CROSS = 9'b0_0100_0000,
    ST_UPD   = 9'b0_1000_0000,
    ST_DONE  = 9'b1_0000_0000
  } state_t;

endpackage

### rtl/core/mep_mul.sv
module mep_mul (
  input  logic                                 clk,
  input  logic signed [mep_pkg::COORD_W-1:0]   a,
  input  logic signed [mep_pkg::COORD_W-1:0]   b,
  output logic signed [mep_pkg::PROD_W-1:0]    p
);

  always_ff @(posedge clk) begin
    p <= mep_pkg::PROD_W'(a * b);
  end

endmodule

### rtl/core/mandelbrot_escape_time_pixel.sv
// Evaluates one pixel of the Mandelbrot set per input word. The pixel is mapped to the complex
// point c in Q4.28 with saturation, then z = z*z + c is iterated from zero until a part of z
// leaves [-2, 2], |z|^2 exceeds 4 or MAX_ITER iterations are done; the result word carries
// the count and 255*count/MAX_ITER. All products go through one registered 32x32 multiplier
// that is used three times per iteration and twice to map the pixel. The input is not ready
// while a pixel is in work; a finished result waits in an output register and the next pixel
// may start meanwhile.
module mandelbrot_escape_time_pixel #(
  parameter int MAX_ITER = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // pixel_x, pixel_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // iteration_count, gray_level
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [mep_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned PW = mep_pkg::PIX_W;
  localparam int unsigned CW = mep_pkg::COORD_W;
  localparam int unsigned ZW = mep_pkg::Z_W;
  localparam int unsigned FW = mep_pkg::FRAC_W;
  localparam int unsigned NW = mep_pkg::COUNT_W;
  localparam int unsigned SW = mep_pkg::SQ_W;

  logic [PW-1:0]        center_x, center_y;
  logic signed [CW-1:0] step_real, step_imag, offset_real, offset_imag;

  mep_pkg::state_t state;

  logic [PW-1:0]        pixel_x, pixel_y;
  logic signed [CW-1:0] cr, ci;
  logic signed [ZW-1:0] zr, zi;
  logic [NW-1:0]        count;
  logic [SW-1:0]        rr;
  logic signed [SW:0]   diff;

  logic signed [CW-1:0] mul_a, mul_b;
  logic signed [mep_pkg::PROD_W-1:0] prod;

  logic signed [PW:0]   dx, dy;
  logic signed [mep_pkg::PROD_W-1:0] map_sum;
  logic signed [CW-1:0] map_sat;
  logic                 out_range;
  logic [SW:0]          rad_sum;
  logic [NW-1:0]        gray_table [2**NW];
  logic                 out_free;

  for (genvar g = 0; g < 2**NW; g++) begin : g_gray
    assign gray_table[g] = NW'((255 * g) / MAX_ITER);
  end

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == mep_pkg::ST_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= mep_pkg::CENTER_X_RST;
      center_y    <= mep_pkg::CENTER_Y_RST;
      step_real   <= mep_pkg::STEP_REAL_RST;
      step_imag   <= mep_pkg::STEP_IMAG_RST;
      offset_real <= mep_pkg::OFFSET_REAL_RST;
      offset_imag <= mep_pkg::OFFSET_IMAG_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mep_pkg::REG_CENTER_X:    center_x    <= cfg_data[PW-1:0];
        mep_pkg::REG_CENTER_Y:    center_y    <= cfg_data[PW-1:0];
        mep_pkg::REG_STEP_REAL:   step_real   <= $signed(cfg_data);
        mep_pkg::REG_STEP_IMAG:   step_imag   <= $signed(cfg_data);
        mep_pkg::REG_OFFSET_REAL: offset_real <= $signed(cfg_data);
        mep_pkg::REG_OFFSET_IMAG: offset_imag <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  assign dx = $signed({1'b0, pixel_x}) - $signed({1'b0, center_x});
  assign dy = $signed({1'b0, pixel_y}) - $signed({1'b0, center_y});

  always_comb begin
    unique case (state)
      mep_pkg::ST_MAP_X: begin
        mul_a = CW'(dx);
        mul_b = step_real;
      end
      mep_pkg::ST_MAP_Y: begin
        mul_a = CW'(dy);
        mul_b = step_imag;
      end
      mep_pkg::ST_SQ_R: begin
        mul_a = zr[CW-1:0];
        mul_b = zr[CW-1:0];
      end
      mep_pkg::ST_SQ_I: begin
        mul_a = zi[CW-1:0];
        mul_b = zi[CW-1:0];
      end
      default: begin
        mul_a = zr[CW-1:0];
        mul_b = zi[CW-1:0];
      end
    endcase
  end

  mep_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  always_comb begin
    if (state == mep_pkg::ST_MAP_C) begin
      map_sum = prod + mep_pkg::PROD_W'(offset_imag);
    end else begin
      map_sum = prod + mep_pkg::PROD_W'(offset_real);
    end
    priority if (map_sum > mep_pkg::COORD_MAX) begin
      map_sat = CW'(mep_pkg::COORD_MAX);
    end else if (map_sum < mep_pkg::COORD_MIN) begin
      map_sat = CW'(mep_pkg::COORD_MIN);
    end else begin
      map_sat = map_sum[CW-1:0];
    end
  end

  assign out_range = (zr > mep_pkg::Z_TWO) || (zr < mep_pkg::Z_NEG_TWO) ||
                     (zi > mep_pkg::Z_TWO) || (zi < mep_pkg::Z_NEG_TWO);
  assign rad_sum   = {1'b0, rr} + {1'b0, prod[SW-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= mep_pkg::ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != mep_pkg::ST_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        mep_pkg::ST_IDLE: begin
          if (s_axis_tvalid) begin
            pixel_x <= s_axis_tdata[PW-1:0];
            pixel_y <= s_axis_tdata[2*PW-1:PW];
            state   <= mep_pkg::ST_MAP_X;
          end
        end
        mep_pkg::ST_MAP_X: state <= mep_pkg::ST_MAP_Y;
        mep_pkg::ST_MAP_Y: begin
          cr    <= map_sat;
          state <= mep_pkg::ST_MAP_C;
        end
        mep_pkg::ST_MAP_C: begin
          ci    <= map_sat;
          zr    <= '0;
          zi    <= '0;
          count <= '0;
          state <= mep_pkg::ST_SQ_R;
        end
        mep_pkg::ST_SQ_R: begin
          if (count == NW'(MAX_ITER) || out_range) begin
            state <= mep_pkg::ST_DONE;
          end else begin
            state <= mep_pkg::ST_SQ_I;
          end
        end
        mep_pkg::ST_SQ_I: begin
          rr    <= prod[SW-1:0];
          state <= mep_pkg::ST_CROSS;
        end
        mep_pkg::ST_CROSS: begin
          diff <= $signed({1'b0, rr}) - $signed({1'b0, prod[SW-1:0]});
          if (rad_sum > mep_pkg::RAD_FOUR) begin
            state <= mep_pkg::ST_DONE;
          end else begin
            state <= mep_pkg::ST_UPD;
          end
        end
        mep_pkg::ST_UPD: begin
          zr    <= ZW'(diff >>> FW) + ZW'(cr);
          zi    <= ZW'(prod >>> (FW - 1)) + ZW'(ci);
          count <= count + 1'b1;
          state <= mep_pkg::ST_SQ_R;
        end
        mep_pkg::ST_DONE: begin
          if (out_free) begin
            m_axis_tdata  <= {gray_table[count], count};
            m_axis_tvalid <= 1'b1;
            state         <= mep_pkg::ST_IDLE;
          end
        end
        default: state <= mep_pkg::ST_IDLE;
      endcase
    end
  end

endmodule

### bench/tb_mandelbrot_escape_time_pixel.sv
module tb_mandelbrot_escape_time_pixel;

  localparam int ITER_LIMIT = 255;
  localparam logic [mep_pkg::CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
  localparam logic [mep_pkg::CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic [7:0] gray;
    logic [7:0] count;
  } shade_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // pixel_x, pixel_y
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // iteration_count, gray_level
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [mep_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  class escape_scoreboard;
    logic [mep_pkg::PIX_W-1:0]          center_x, center_y;
    logic signed [mep_pkg::COORD_W-1:0] step_real, step_imag, offset_real, offset_imag;
    shade_t                             expected_shades[$];
    int                                 failures;

    function new();
      center_x    = mep_pkg::CENTER_X_RST;
      center_y    = mep_pkg::CENTER_Y_RST;
      step_real   = mep_pkg::STEP_REAL_RST;
      step_imag   = mep_pkg::STEP_IMAG_RST;
      offset_real = mep_pkg::OFFSET_REAL_RST;
      offset_imag = mep_pkg::OFFSET_IMAG_RST;
      failures    = 0;
    endfunction

    function void write_reg(logic [mep_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        mep_pkg::REG_CENTER_X:    center_x = data[mep_pkg::PIX_W-1:0];
        mep_pkg::REG_CENTER_Y:    center_y = data[mep_pkg::PIX_W-1:0];
        mep_pkg::REG_STEP_REAL:   step_real = data;
        mep_pkg::REG_STEP_IMAG:   step_imag = data;
        mep_pkg::REG_OFFSET_REAL: offset_real = data;
        mep_pkg::REG_OFFSET_IMAG: offset_imag = data;
        default: ;
      endcase
    endfunction

    // Maps a pixel onto one axis and clamps the sum to the Q4.28 range.
    function longint map_axis(logic [mep_pkg::PIX_W-1:0] pix, logic [mep_pkg::PIX_W-1:0] ctr,
                              logic signed [mep_pkg::COORD_W-1:0] step,
                              logic signed [mep_pkg::COORD_W-1:0] offs);
      longint v;
      v = (longint'(pix) - longint'(ctr)) * longint'(step) + longint'(offs);
      if (v > longint'(mep_pkg::COORD_MAX)) v = longint'(mep_pkg::COORD_MAX);
      if (v < longint'(mep_pkg::COORD_MIN)) v = longint'(mep_pkg::COORD_MIN);
      return v;
    endfunction

    function void note_pixel(logic [mep_pkg::PIX_W-1:0] x, logic [mep_pkg::PIX_W-1:0] y);
      longint cr, ci, zr, zi, re2, cross_term, bound, four;
      int     n;
      shade_t s;
      cr    = map_axis(x, center_x, step_real, offset_real);
      ci    = map_axis(y, center_y, step_imag, offset_imag);
      zr    = 0;
      zi    = 0;
      bound = longint'(2) << mep_pkg::FRAC_W;
      four  = longint'(4) << (2 * mep_pkg::FRAC_W);
      for (n = 0; n < ITER_LIMIT; n++) begin
        if (zr > bound || zr < -bound || zi > bound || zi < -bound) break;
        if (zr * zr + zi * zi > four) break;
        re2        = zr * zr - zi * zi;
        cross_term = 2 * zr * zi;
        zr         = (re2 >>> mep_pkg::FRAC_W) + cr;
        zi         = (cross_term >>> mep_pkg::FRAC_W) + ci;
      end
      s.count = 8'(n);
      s.gray  = 8'(255 * n / ITER_LIMIT);
      expected_shades.push_back(s);
    endfunction

    function void check_shade(shade_t got);
      shade_t want;
      if (expected_shades.size() == 0) begin
        $error("result word with no pixel pending: count %0d gray %0d", got.count, got.gray);
        failures++;
        return;
      end
      want = expected_shades.pop_front();
      if (got.count !== want.count) begin
        $error("iteration_count: expected %0d, got %0d", want.count, got.count);
        failures++;
      end
      if (got.gray !== want.gray) begin
        $error("gray_level: expected %0d, got %0d", want.gray, got.gray);
        failures++;
      end
    endfunction

    function int pending();
      return expected_shades.size();
    endfunction
  endclass

  escape_scoreboard sb;

  mandelbrot_escape_time_pixel #(.MAX_ITER(ITER_LIMIT)) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30000000;
    $display("tb_mandelbrot_escape_time_pixel failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_shade(m_axis_tdata);
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(50, 300);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 1) == 1);
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_pixel(input logic [mep_pkg::PIX_W-1:0] x,
                            input logic [mep_pkg::PIX_W-1:0] y);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 30);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_pixel(x, y);
    burst_left--;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [mep_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic set_view(input logic [31:0] cx, cy, sr, si, offr, offi);
    drain_results();
    cfg_write(REG_UNUSED_6, $urandom());
    cfg_write(mep_pkg::REG_CENTER_X, cx);
    cfg_write(mep_pkg::REG_CENTER_Y, cy);
    cfg_write(mep_pkg::REG_STEP_REAL, sr);
    cfg_write(mep_pkg::REG_STEP_IMAG, si);
    cfg_write(mep_pkg::REG_OFFSET_REAL, offr);
    cfg_write(mep_pkg::REG_OFFSET_IMAG, offi);
    cfg_write(REG_UNUSED_7, $urandom());
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [mep_pkg::PIX_W-1:0] near_pixel(logic [mep_pkg::PIX_W-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 400)) - 200;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[mep_pkg::PIX_W-1:0];
  endfunction

  task automatic run_pixels(input int n);
    logic [mep_pkg::PIX_W-1:0] x, y;
    int k;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 49) == 0) drain_results();
      if ($urandom_range(0, 3) != 0) begin
        x = near_pixel(sb.center_x);
        y = near_pixel(sb.center_y);
      end else begin
        x = mep_pkg::PIX_W'($urandom_range(0, 4095));
        y = mep_pkg::PIX_W'($urandom_range(0, 4095));
      end
      send_pixel(x, y);
    end
  endtask

  initial begin
    int p, mag, sr, si;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd400, 12'd300);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);
    send_pixel(12'd229, 12'd300);
    send_pixel(12'd571, 12'd300);
    send_pixel(12'd400, 12'd529);
    run_pixels(100);

    // Extreme register values; the center writes carry junk above bit 11.
    set_view(32'hFFFF_F000, 32'hABCD_EFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h8000_0000);
    run_pixels(40);

    // Points on the radius-two circle, where the escape test compares equal to four.
    set_view(0, 0, 0, 0, -536870912, 0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    set_view(0, 0, 0, 0, 536870912, 0);
    send_pixel(12'd1234, 12'd3210);
    set_view(0, 0, 0, 0, 0, 536870912);
    send_pixel(12'd4095, 12'd0);
    set_view(0, 0, 0, 0, 0, -536870912);
    send_pixel(12'd0, 12'd4095);

    for (p = 0; p < 5; p++) begin
      if (p == 4) begin
        set_view($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      end else begin
        mag = $urandom_range(1 << 14, 1 << 22);
        sr  = ($urandom_range(0, 1) == 1) ? mag : -mag;
        mag = $urandom_range(1 << 14, 1 << 22);
        si  = ($urandom_range(0, 1) == 1) ? mag : -mag;
        set_view($urandom_range(0, 4095), $urandom_range(0, 4095), sr, si,
                 int'($urandom_range(0, 751619276)) - 590558003,
                 int'($urandom_range(0, 644245094)) - 322122547);
      end
      run_pixels(50);
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (sb.failures == 0) $display("tb_mandelbrot_escape_time_pixel passed");
    else $display("tb_mandelbrot_escape_time_pixel failed");
    $finish;
  end

endmodule

### mandelbrot_escape_time_pixel.f
rtl/core/mep_pkg.sv
rtl/core/mep_mul.sv
rtl/core/mandelbrot_escape_time_pixel.sv
bench/tb_mandelbrot_escape_time_pixel.sv
